FILE: src/agms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// agms_pkg: shared types and constants of the adaptive gain mode selector
// mode codes, action codes, register map, item/result/config structs
// ----------------------------------------------------------------------------
package agms_pkg;

  // gain mode codes
  localparam logic [2:0] MODE_AUTO  = 3'd0;
  localparam logic [2:0] MODE_VHIGH = 3'd1;
  localparam logic [2:0] MODE_HIGH  = 3'd2;
  localparam logic [2:0] MODE_MED   = 3'd3;
  localparam logic [2:0] MODE_LOW   = 3'd4;
  localparam logic [2:0] MODE_VLOW  = 3'd5;

  // action codes
  localparam logic [1:0] ACT_RECOMMEND = 2'd0;
  localparam logic [1:0] ACT_USER      = 2'd1;
  localparam logic [1:0] ACT_MEASURE   = 2'd2;

  // amplifier range codes
  localparam logic [1:0] GAIN_1V024 = 2'd0;
  localparam logic [1:0] GAIN_2V048 = 2'd1;
  localparam logic [1:0] GAIN_4V096 = 2'd2;

  // register indexes
  localparam logic [2:0] REG_LOCKOUT    = 3'd0;
  localparam logic [2:0] REG_NOISE_LOW  = 3'd1;
  localparam logic [2:0] REG_NOISE_VLOW = 3'd2;
  localparam logic [2:0] REG_UP_HIGH    = 3'd3;
  localparam logic [2:0] REG_UP_VHIGH   = 3'd4;
  localparam logic [2:0] REG_DN_HIGH    = 3'd5;
  localparam logic [2:0] REG_DN_VHIGH   = 3'd6;
  localparam logic [2:0] REG_ALPHA      = 3'd7;

  localparam int unsigned ADDR_W = 5;

  // register reset values
  localparam logic [15:0] RST_LOCKOUT    = 16'd1200;
  localparam logic [23:0] RST_NOISE_LOW  = 24'd3072;
  localparam logic [23:0] RST_NOISE_VLOW = 24'd7680;
  localparam logic [15:0] RST_UP_HIGH    = 16'd768;
  localparam logic [15:0] RST_UP_VHIGH   = 16'd1536;
  localparam logic [15:0] RST_DN_HIGH    = 16'd512;
  localparam logic [15:0] RST_DN_VHIGH   = 16'd1152;
  localparam logic [15:0] RST_ALPHA      = 16'd3277;

  // stability limits 70.0 and 85.0 in Q7.8, noise floor 0.02 in Q16.8
  localparam logic [14:0] STAB_MED  = 15'd17920;
  localparam logic [14:0] STAB_HIGH = 15'd21760;
  localparam logic [23:0] NOISE_MIN = 24'd5;

  typedef struct packed {
    logic [15:0] lockout_ms;
    logic [23:0] noise_low_thresh;
    logic [23:0] noise_very_low_thresh;
    logic [15:0] snr_up_high;
    logic [15:0] snr_up_very_high;
    logic [15:0] snr_down_from_high;
    logic [15:0] snr_down_from_very_high;
    logic [15:0] ema_alpha;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  mode;
    logic [23:0] noise_sd;
    logic [15:0] snr;
    logic [14:0] stability;
    logic        stable;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic       applied;
    logic [2:0] active_mode;
    logic [1:0] gain_select;
    logic [2:0] selected_mode;
    logic       override_active;
    logic [2:0] recommended;
  } result_t;

endpackage : agms_pkg
`default_nettype wire

FILE: src/adaptive_gain_mode_selector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_gain_mode_selector_top: sensor gain mode selector
// input register, one-pass mode engine, result register, apb config port
// ----------------------------------------------------------------------------
// Takes one word per clock on the input channel while out_stall is low and
// returns exactly one result word for each, in order. The word is captured in
// an input register, then the engine resolves the mode, updates the noise
// average and the auto decision state, and loads the result register.
// Sustained rate is one word per cycle while out_stall is low; it is set by the
// state loop through the noise average multiply (25 x 17 bits) and the threshold
// compares that feed the next mode. The result register parts the two sides:
// while a result waits under out_stall the input register still takes a new
// word, and in_stall rises only when both are full. Registers are written over
// the apb port (byte address 4*index, pready always high) and must only be
// changed while no word is in flight. After reset the mode is medium, the
// average is zero and the auto engine waits for its first measurement.
// ----------------------------------------------------------------------------
module adaptive_gain_mode_selector_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_action,
  input  wire logic [2:0]                  in_mode,
  input  wire logic [23:0]                 in_noise_sd,
  input  wire logic [15:0]                 in_snr,
  input  wire logic [14:0]                 in_stability,
  input  wire logic                        in_stable,
  input  wire logic [31:0]                 in_now_ms,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_applied,
  output logic      [2:0]                  out_active_mode,
  output logic      [1:0]                  out_gain_select,
  output logic      [2:0]                  out_selected_mode,
  output logic                             out_override_active,
  output logic      [2:0]                  out_recommended,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [agms_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import agms_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  result_t res;
  result_t res_r;
  logic    res_vld_r;
  logic    advance;
  logic    step;
  logic    in_take;

  agms_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // result register moves when empty or when its word is being taken
  assign advance  = !res_vld_r || !out_stall;
  // the held word goes through the engine as the result register frees up
  assign step     = item_vld_r && advance;
  // input register is free when empty or draining this cycle
  assign in_stall = item_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_take) begin
      item_vld_r <= 1'b1;
    end else if (step) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action    <= in_action;
      item_r.mode      <= in_mode;
      item_r.noise_sd  <= in_noise_sd;
      item_r.snr       <= in_snr;
      item_r.stability <= in_stability;
      item_r.stable    <= in_stable;
      item_r.now_ms    <= in_now_ms;
    end
  end

  // mode state and decision, committed on step
  agms_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid           = res_vld_r;
  assign out_applied         = res_r.applied;
  assign out_active_mode     = res_r.active_mode;
  assign out_gain_select     = res_r.gain_select;
  assign out_selected_mode   = res_r.selected_mode;
  assign out_override_active = res_r.override_active;
  assign out_recommended     = res_r.recommended;

`ifndef NO_ASSERTIONS
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_vld_r && res_vld_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_step_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> res_vld_r)
    else $error("processed word did not reach the result register");

  a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && out_stall) |=> (res_vld_r && $stable(res_r)))
    else $error("stalled result changed");
`endif

endmodule : adaptive_gain_mode_selector_top
`default_nettype wire

FILE: src/agms_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// agms_regs: configuration register file
// apb-style write and read of the eight threshold and timing registers
// ----------------------------------------------------------------------------
module agms_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [agms_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output agms_pkg::cfg_t                   cfg
);
  import agms_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lockout_ms              <= RST_LOCKOUT;
      cfg_r.noise_low_thresh        <= RST_NOISE_LOW;
      cfg_r.noise_very_low_thresh   <= RST_NOISE_VLOW;
      cfg_r.snr_up_high             <= RST_UP_HIGH;
      cfg_r.snr_up_very_high        <= RST_UP_VHIGH;
      cfg_r.snr_down_from_high      <= RST_DN_HIGH;
      cfg_r.snr_down_from_very_high <= RST_DN_VHIGH;
      cfg_r.ema_alpha               <= RST_ALPHA;
    end else if (wr_en) begin
      unique case (idx)
        REG_LOCKOUT:    cfg_r.lockout_ms              <= pwdata[15:0];
        REG_NOISE_LOW:  cfg_r.noise_low_thresh        <= pwdata[23:0];
        REG_NOISE_VLOW: cfg_r.noise_very_low_thresh   <= pwdata[23:0];
        REG_UP_HIGH:    cfg_r.snr_up_high             <= pwdata[15:0];
        REG_UP_VHIGH:   cfg_r.snr_up_very_high        <= pwdata[15:0];
        REG_DN_HIGH:    cfg_r.snr_down_from_high      <= pwdata[15:0];
        REG_DN_VHIGH:   cfg_r.snr_down_from_very_high <= pwdata[15:0];
        REG_ALPHA:      cfg_r.ema_alpha               <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOCKOUT:    prdata = {16'd0, cfg_r.lockout_ms};
      REG_NOISE_LOW:  prdata = {8'd0, cfg_r.noise_low_thresh};
      REG_NOISE_VLOW: prdata = {8'd0, cfg_r.noise_very_low_thresh};
      REG_UP_HIGH:    prdata = {16'd0, cfg_r.snr_up_high};
      REG_UP_VHIGH:   prdata = {16'd0, cfg_r.snr_up_very_high};
      REG_DN_HIGH:    prdata = {16'd0, cfg_r.snr_down_from_high};
      REG_DN_VHIGH:   prdata = {16'd0, cfg_r.snr_down_from_very_high};
      REG_ALPHA:      prdata = {16'd0, cfg_r.ema_alpha};
      default:        prdata = 32'd0;
    endcase
  end

endmodule : agms_regs
`default_nettype wire

FILE: src/agms_ema.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// agms_ema: noise average update
// avg + alpha*(nf - avg) in Q0.16, rounded half up, clamped to the noise floor
// ----------------------------------------------------------------------------
module agms_ema (
  input  wire logic [23:0] avg,
  input  wire logic [23:0] noise_sd,
  input  wire logic [15:0] alpha,
  output logic      [23:0] avg_nxt
);
  import agms_pkg::*;

  logic signed [24:0] diff;
  logic signed [41:0] prod;
  logic signed [41:0] acc;
  logic        [23:0] quo;

  // same as (65536 - alpha)*avg + alpha*nf, with a single multiplier
  assign diff = $signed({1'b0, noise_sd}) - $signed({1'b0, avg});
  assign prod = 42'(diff * $signed({1'b0, alpha}));
  assign acc  = $signed({2'b00, avg, 16'd0}) + prod + 42'sd32768;
  assign quo  = acc[39:16];

  assign avg_nxt = (quo < NOISE_MIN) ? NOISE_MIN : quo;

endmodule : agms_ema
`default_nettype wire

FILE: src/agms_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// agms_engine: mode state and decision logic
// applies recommendations and user selects, runs the gated auto decision
// ----------------------------------------------------------------------------
module agms_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire agms_pkg::item_t   item,
  input  wire agms_pkg::cfg_t    cfg,
  output agms_pkg::result_t      res
);
  import agms_pkg::*;

  logic [2:0]  requested_r, requested_nxt;
  logic [2:0]  recommended_r, recommended_nxt;
  logic [2:0]  resolved_r, resolved_nxt;
  logic        manual_r, manual_nxt;
  logic        started_r, started_nxt;
  logic [23:0] avg_r, avg_nxt;
  logic [2:0]  auto_last_r, auto_last_nxt;
  logic [31:0] last_change_r, last_change_nxt;

  logic [23:0] ema_avg;
  logic [2:0]  mode_c;
  logic [31:0] elapsed;
  logic [2:0]  target;
  logic        applied;
  logic        up_vh, up_h;

  agms_ema u_ema (
    .avg      (avg_r),
    .noise_sd (item.noise_sd),
    .alpha    (cfg.ema_alpha),
    .avg_nxt  (ema_avg)
  );

  // out-of-range mode codes count as medium
  assign mode_c  = (item.mode > MODE_VLOW) ? MODE_MED : item.mode;
  assign elapsed = item.now_ms - last_change_r;

  // hysteretic choice on the fresh average
  assign up_vh = (item.snr >= cfg.snr_up_very_high) && (item.stability >= STAB_HIGH);
  assign up_h  = (item.snr >= cfg.snr_up_high) && (item.stability >= STAB_MED);

  always_comb begin
    if (ema_avg >= cfg.noise_very_low_thresh) begin
      target = MODE_VLOW;
    end else if (ema_avg >= cfg.noise_low_thresh) begin
      target = MODE_LOW;
    end else if (auto_last_r == MODE_VHIGH) begin
      if ((item.snr >= cfg.snr_down_from_very_high) && (item.stability >= STAB_HIGH))
        target = MODE_VHIGH;
      else if (up_h)
        target = MODE_HIGH;
      else
        target = MODE_MED;
    end else if (auto_last_r == MODE_HIGH) begin
      if ((item.snr < cfg.snr_down_from_high) || (item.stability < STAB_MED))
        target = MODE_MED;
      else if (up_vh)
        target = MODE_VHIGH;
      else
        target = MODE_HIGH;
    end else if (up_vh) begin
      target = MODE_VHIGH;
    end else if (up_h) begin
      target = MODE_HIGH;
    end else begin
      target = MODE_MED;
    end
  end

  always_comb begin
    requested_nxt   = requested_r;
    recommended_nxt = recommended_r;
    resolved_nxt    = resolved_r;
    manual_nxt      = manual_r;
    started_nxt     = started_r;
    avg_nxt         = avg_r;
    auto_last_nxt   = auto_last_r;
    last_change_nxt = last_change_r;
    applied         = 1'b0;
    case (item.action)
      ACT_RECOMMEND: begin
        recommended_nxt = mode_c;
        if (!manual_r) begin
          requested_nxt = mode_c;
          // auto resolves to the new recommendation; an auto recommendation gives medium
          resolved_nxt  = (mode_c == MODE_AUTO) ? MODE_MED : mode_c;
          applied       = 1'b1;
        end
      end
      ACT_USER: begin
        manual_nxt    = (mode_c != MODE_AUTO);
        requested_nxt = mode_c;
        if (mode_c != MODE_AUTO)
          resolved_nxt = mode_c;
        else if (recommended_r == MODE_AUTO)
          resolved_nxt = MODE_MED;
        else
          resolved_nxt = recommended_r;
        applied = 1'b1;
      end
      ACT_MEASURE: begin
        if (!manual_r && (requested_r == MODE_AUTO)) begin
          if (!started_r) begin
            started_nxt     = 1'b1;
            avg_nxt         = item.noise_sd;
            auto_last_nxt   = resolved_r;
            last_change_nxt = item.now_ms;
          end else begin
            avg_nxt = ema_avg;
            if (item.stable && (elapsed >= {16'd0, cfg.lockout_ms}) &&
                (target != auto_last_r)) begin
              resolved_nxt    = target;
              auto_last_nxt   = target;
              last_change_nxt = item.now_ms;
              applied         = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.applied         = applied;
    res.active_mode     = resolved_nxt;
    res.selected_mode   = requested_nxt;
    res.override_active = manual_nxt;
    res.recommended     = recommended_nxt;
    if (resolved_nxt <= MODE_HIGH)
      res.gain_select = GAIN_1V024;
    else if (resolved_nxt == MODE_MED)
      res.gain_select = GAIN_2V048;
    else
      res.gain_select = GAIN_4V096;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      requested_r   <= MODE_MED;
      recommended_r <= MODE_MED;
      resolved_r    <= MODE_MED;
      manual_r      <= 1'b0;
      started_r     <= 1'b0;
      avg_r         <= 24'd0;
      auto_last_r   <= MODE_AUTO;
      last_change_r <= 32'd0;
    end else if (step) begin
      requested_r   <= requested_nxt;
      recommended_r <= recommended_nxt;
      resolved_r    <= resolved_nxt;
      manual_r      <= manual_nxt;
      started_r     <= started_nxt;
      avg_r         <= avg_nxt;
      auto_last_r   <= auto_last_nxt;
      last_change_r <= last_change_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_resolved_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (resolved_r != MODE_AUTO) && (resolved_r <= MODE_VLOW))
    else $error("resolved mode out of range");

  a_manual_not_auto: assert property (@(posedge clk) disable iff (!rst_n)
    manual_r |-> (requested_r != MODE_AUTO))
    else $error("override active with auto request");

  a_started_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("engine start flag dropped");

  a_auto_change_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (item.action == ACT_MEASURE) && applied) |=>
      ((auto_last_r == resolved_r) && (requested_r == MODE_AUTO)))
    else $error("auto change lost track of the resolved mode");
`endif

endmodule : agms_engine
`default_nettype wire
